/* src/matrix_rectangle_sum_macros.svh */
// Assertion macros for the rectangle-sum block.
// Each sampled at the rising edge of clk, ignored while rst_n is low.
`ifndef MATRIX_RECTANGLE_SUM_MACROS_SVH
`define MATRIX_RECTANGLE_SUM_MACROS_SVH

`ifndef SYNTH
`define MRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MRS_ASSERT_IMP(lbl, ante, cons)
`define MRS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/mrs_pkg.sv */
package mrs_pkg;

  localparam int SUM_W   = 28;
  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [COORD_W-1:0]       elem_row;
    logic [COORD_W-1:0]       elem_col;
    logic signed [15:0]       elem_value;
    logic [COORD_W-1:0]       top_row;
    logic [COORD_W-1:0]       left_col;
    logic [COORD_W-1:0]       bottom_row;
    logic [COORD_W-1:0]       right_col;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  rect_sum;
    logic                     bad_coords;
  } out_item_t;

endpackage

/* src/matrix_rectangle_sum.sv */
// Rectangle-sum block over a matrix held in one synchronous RAM.
//
// Input channel: an item is taken at a rising edge where start is high and
// busy is low. cmd = write stores elem_value at (elem_row, elem_col); a write
// outside the rows/columns in use is dropped. Writes give no
// result, and busy never rises for them.
// cmd = query sums the inclusive rectangle (top_row, left_col) to
// (bottom_row, right_col). The scan reads one element per cycle from the
// RAM's read port, with busy held through the scan and the drain state
// that follows it; the result comes out as the drain state ends. A bad
// query (corner out of range or misordered) returns bad_coords with a
// zero sum in the cycle after the accept edge.
// Result channel: out_valid is high for exactly one cycle with out_item;
// the receiver cannot stall it, and the block is already free again then.
// Config port: cfg_we writes cfg_wdata into register cfg_index (rows_in_use
// or cols_in_use) at the edge; write only while idle.
// Reset (rst_n low at an edge) returns the FSM to idle and both sizes to 64.
// The RAM is not cleared: reading an element never written is undefined.
module matrix_rectangle_sum
  import mrs_pkg::*;
#(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int ELEM_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata
);

`include "matrix_rectangle_sum_macros.svh"

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t                  state_r;
  logic [SIZE_W-1:0]       rows_in_use_r;
  logic [SIZE_W-1:0]       cols_in_use_r;
  logic [COORD_W-1:0]      row_r;
  logic [COORD_W-1:0]      col_r;
  logic [COORD_W-1:0]      left_r;
  logic [COORD_W-1:0]      bottom_r;
  logic [COORD_W-1:0]      right_r;
  logic                    rd_vld_r;
  logic signed [SUM_W-1:0] acc_r;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  // Element storage, one write port and one read port.
  logic [ELEM_BITS-1:0]    mem [DEPTH];
  logic [ELEM_BITS-1:0]    rd_data_r;

  logic                    accept;
  logic                    wr_ok;
  logic                    query_bad;
  logic                    scan_last;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ELEM_BITS-1:0]    wr_data;
  logic signed [31:0]      elem_wide;
  logic signed [SUM_W-1:0] elem_ext;
  logic signed [SUM_W-1:0] acc_sum;

  // A coordinate is in range when it is below both the size in use and
  // the physical store size.
  function automatic logic row_in_range(logic [COORD_W-1:0] r, logic [SIZE_W-1:0] n);
    return ({1'b0, r} < n) && (32'(r) < MAX_ROWS);
  endfunction

  function automatic logic col_in_range(logic [COORD_W-1:0] c, logic [SIZE_W-1:0] n);
    return ({1'b0, c} < n) && (32'(c) < MAX_COLS);
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  assign wr_ok = row_in_range(in_item.elem_row, rows_in_use_r) &&
                 col_in_range(in_item.elem_col, cols_in_use_r);

  assign query_bad = !row_in_range(in_item.top_row, rows_in_use_r)    ||
                     !row_in_range(in_item.bottom_row, rows_in_use_r) ||
                     !col_in_range(in_item.left_col, cols_in_use_r)   ||
                     !col_in_range(in_item.right_col, cols_in_use_r)  ||
                     (in_item.top_row > in_item.bottom_row)           ||
                     (in_item.left_col > in_item.right_col);

  assign wr_addr = ADDR_W'(ADDR_W'(in_item.elem_row) * ADDR_W'(MAX_COLS)
                           + ADDR_W'(in_item.elem_col));
  assign rd_addr = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(MAX_COLS) + ADDR_W'(col_r));
  assign wr_data = ELEM_BITS'(in_item.elem_value);

  assign scan_last = (row_r == bottom_r) && (col_r == right_r);

  // Sign-extend the stored element, then wrap to the sum width.
  assign elem_wide = 32'(signed'(rd_data_r));
  assign elem_ext  = elem_wide[SUM_W-1:0];
  assign acc_sum   = acc_r + elem_ext;

  // Writes land only in idle; scan reads start the cycle after, so no
  // read can overlap a write to the same entry.
  always_ff @(posedge clk) begin
    if (accept && (in_item.cmd == CMD_WRITE) && wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rows_in_use_r <= SIZE_W'(64);
      cols_in_use_r <= SIZE_W'(64);
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_vld_r    <= (state_r == ST_SCAN);

      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_IN_USE: rows_in_use_r <= cfg_wdata;
          REG_COLS_IN_USE: cols_in_use_r <= cfg_wdata;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (accept && (in_item.cmd == CMD_QUERY)) begin
            if (query_bad) begin
              // Answer a bad query at once with a zero sum.
              out_valid_r           <= 1'b1;
              out_item_r.rect_sum   <= '0;
              out_item_r.bad_coords <= 1'b1;
            end else begin
              row_r    <= in_item.top_row;
              col_r    <= in_item.left_col;
              left_r   <= in_item.left_col;
              bottom_r <= in_item.bottom_row;
              right_r  <= in_item.right_col;
              acc_r    <= '0;
              state_r  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle; fold in the data of the read before.
          if (rd_vld_r) begin
            acc_r <= acc_sum;
          end
          if (scan_last) begin
            state_r <= ST_DRAIN;
          end else if (col_r == right_r) begin
            col_r <= left_r;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          // Last element arrives now; deliver the total.
          out_valid_r           <= 1'b1;
          out_item_r.rect_sum   <= acc_sum;
          out_item_r.bad_coords <= 1'b0;
          state_r               <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A write never produces a result.
  `MRS_ASSERT_NXT(a_write_silent, accept && (in_item.cmd == CMD_WRITE), !out_valid_r)
  // Drain always ends in exactly one result and a return to idle.
  `MRS_ASSERT_NXT(a_drain_done, state_r == ST_DRAIN, out_valid_r && (state_r == ST_IDLE))
  // A flagged result carries a zero sum.
  `MRS_ASSERT_IMP(a_bad_zero, out_valid_r && out_item_r.bad_coords,
                  out_item_r.rect_sum == '0)
  // In the drain state the data of the last scan read is valid.
  `MRS_ASSERT_IMP(a_drain_data, state_r == ST_DRAIN, rd_vld_r)

endmodule
